/* design/certainty_grid_update_core_macros.svh */
// assertion macros for the certainty grid update core
// expects aclk and aresetn in the scope of each use
`ifndef CERTAINTY_GRID_UPDATE_CORE_MACROS_SVH
`define CERTAINTY_GRID_UPDATE_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define CGU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define CGU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cgu_pkg.sv */
// shared types, constants and trig table of the certainty grid update core
// no dependencies
package cgu_pkg;

    localparam int CGU_GRID_MAX   = 64;
    localparam int CGU_COUNT_BITS = 16;

    localparam int DIST_W    = 16;
    localparam int SIDE_CFG_W = 7;
    localparam int COORD_OUT_W = 6;
    localparam int COUNT_OUT_W = 16;
    localparam int BRG_W     = 9;
    localparam int TRIG_W    = 17;
    localparam int FRAC_BITS = 15;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 1'd1;

    localparam logic [DIST_W-1:0]     CELL_SIZE_RST = 16'd1;
    localparam logic [SIDE_CFG_W-1:0] GRID_SIDE_RST = 7'd63;

    localparam logic [BRG_W-1:0] DEG_QUARTER = 9'd90;
    localparam logic [BRG_W-1:0] DEG_HALF    = 9'd180;
    localparam logic [BRG_W-1:0] DEG_3QUART  = 9'd270;
    localparam logic [BRG_W-1:0] DEG_FULL    = 9'd360;

    // sine of 0..90 degrees, scale 2^15, round to nearest
    localparam logic signed [TRIG_W-1:0] SIN_Q [91] = '{
        17'sd0,     17'sd572,   17'sd1144,  17'sd1715,  17'sd2286,
        17'sd2856,  17'sd3425,  17'sd3993,  17'sd4560,  17'sd5126,
        17'sd5690,  17'sd6252,  17'sd6813,  17'sd7371,  17'sd7927,
        17'sd8481,  17'sd9032,  17'sd9580,  17'sd10126, 17'sd10668,
        17'sd11207, 17'sd11743, 17'sd12275, 17'sd12803, 17'sd13328,
        17'sd13848, 17'sd14365, 17'sd14876, 17'sd15384, 17'sd15886,
        17'sd16384, 17'sd16877, 17'sd17364, 17'sd17847, 17'sd18324,
        17'sd18795, 17'sd19261, 17'sd19720, 17'sd20174, 17'sd20622,
        17'sd21063, 17'sd21498, 17'sd21926, 17'sd22348, 17'sd22763,
        17'sd23170, 17'sd23571, 17'sd23965, 17'sd24351, 17'sd24730,
        17'sd25102, 17'sd25466, 17'sd25822, 17'sd26170, 17'sd26510,
        17'sd26842, 17'sd27166, 17'sd27482, 17'sd27789, 17'sd28088,
        17'sd28378, 17'sd28660, 17'sd28932, 17'sd29197, 17'sd29452,
        17'sd29698, 17'sd29935, 17'sd30163, 17'sd30382, 17'sd30592,
        17'sd30792, 17'sd30983, 17'sd31164, 17'sd31336, 17'sd31499,
        17'sd31651, 17'sd31795, 17'sd31928, 17'sd32052, 17'sd32166,
        17'sd32270, 17'sd32365, 17'sd32449, 17'sd32524, 17'sd32588,
        17'sd32643, 17'sd32688, 17'sd32723, 17'sd32748, 17'sd32763,
        17'sd32768
    };

    typedef struct packed {
        logic [COORD_OUT_W-1:0] robot_x;
        logic [COORD_OUT_W-1:0] robot_y;
        logic [DIST_W-1:0]      range_dist;
        logic [BRG_W-1:0]       bearing_deg;
    } in_word_t;

    typedef struct packed {
        logic                   in_grid;
        logic [COORD_OUT_W-1:0] hit_x;
        logic [COORD_OUT_W-1:0] hit_y;
        logic [COUNT_OUT_W-1:0] hit_count;
    } out_word_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic div_step;
        logic mul;
        logic pos;
        logic addr;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic out_busy;
    } ctl_sts_t;

    // sine of a bearing in 0..359
    function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [BRG_W-1:0] d);
        logic [BRG_W-1:0] a;
        if (d <= DEG_QUARTER) begin
            return SIN_Q[d[6:0]];
        end else if (d <= DEG_HALF) begin
            a = DEG_HALF - d;
            return SIN_Q[a[6:0]];
        end else if (d <= DEG_3QUART) begin
            a = d - DEG_HALF;
            return -SIN_Q[a[6:0]];
        end else begin
            a = DEG_FULL - d;
            return -SIN_Q[a[6:0]];
        end
    endfunction

endpackage

/* design/cgu_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module cgu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/cgu_ctrl.sv */
// sequencer of the certainty grid update core: clear pass, divide, locate, update
// depends on cgu_pkg
module cgu_ctrl
    import cgu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_POS   = 8'b0001_0000,
        ST_ADDR  = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_POS;
            end
            ST_POS: begin
                cmd.pos    = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                // ram read of the target cell in flight
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/cgu_datapath.sv */
// datapath of the certainty grid update core: config, divider, trig multiply,
// cell locate, count ram update and output register; depends on cgu_pkg, cgu_ram
`include "certainty_grid_update_core_macros.svh"

module cgu_datapath
    import cgu_pkg::*;
#(
    parameter int GRID_MAX   = CGU_GRID_MAX,
    parameter int COUNT_BITS = CGU_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_word_t              s_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output out_word_t             m_data,
    input  ctl_cmd_t              cmd,
    output ctl_sts_t              sts
);

    localparam int DEPTH   = GRID_MAX * GRID_MAX;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int SIDE_W  = $clog2(GRID_MAX + 1);
    localparam int COORD_W = $clog2(GRID_MAX);
    localparam int CNT_W   = $clog2(DIST_W);
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int POS_W   = DIST_W + 3;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration
    logic [DIST_W-1:0]     cell_size_reg;
    logic [SIDE_CFG_W-1:0] grid_side_reg;
    logic [DIST_W-1:0]     divisor;
    logic [SIDE_W-1:0]     side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg <= CELL_SIZE_RST;
            grid_side_reg <= GRID_SIDE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CELL_SIZE: cell_size_reg <= cfg_wdata;
                CFG_GRID_SIDE: grid_side_reg <= cfg_wdata[SIDE_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign divisor = (cell_size_reg == '0) ? DIST_W'(1) : cell_size_reg;

    always_comb begin
        if (32'(grid_side_reg) > GRID_MAX) begin
            side = SIDE_W'(GRID_MAX);
        end else begin
            side = SIDE_W'(grid_side_reg);
        end
    end

    // clearing pass over the count ram
    logic [IDX_W-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == IDX_W'(DEPTH - 1));

    // word capture and trig lookup
    logic [BRG_W-1:0] brg_mod;
    logic [BRG_W-1:0] brg_cos_raw;
    logic [BRG_W-1:0] brg_cos;
    logic [COORD_OUT_W-1:0] rx_reg, ry_reg;
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;

    always_comb begin
        brg_mod     = (s_data.bearing_deg >= DEG_FULL) ? s_data.bearing_deg - DEG_FULL
                                                       : s_data.bearing_deg;
        brg_cos_raw = brg_mod + DEG_QUARTER;
        brg_cos     = (brg_cos_raw >= DEG_FULL) ? brg_cos_raw - DEG_FULL : brg_cos_raw;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rx_reg  <= s_data.robot_x;
            ry_reg  <= s_data.robot_y;
            sin_reg <= sine_deg(brg_mod);
            cos_reg <= sine_deg(brg_cos);
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [DIST_W-1:0] rem_reg, rem_next;
    logic [DIST_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [DIST_W:0]   shifted;
    logic [DIST_W:0]   diff;
    logic              take;

    always_comb begin
        shifted  = {rem_reg, dvd_reg[DIST_W-1]};
        diff     = shifted - {1'b0, divisor};
        take     = (shifted >= {1'b0, divisor});
        rem_next = take ? diff[DIST_W-1:0] : shifted[DIST_W-1:0];
        dvd_next = {dvd_reg[DIST_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.load) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg <= '0;
            dvd_reg <= s_data.range_dist;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign sts.div_last = (div_cnt_reg == CNT_W'(DIST_W - 1));

    // quotient times cos and sin
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [TRIG_W-1:0] quo_s;

    assign quo_s = $signed({1'b0, dvd_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_x_reg <= quo_s * cos_reg;
            prod_y_reg <= quo_s * sin_reg;
        end
    end

    // floor of the products gives the offsets; range check against the side
    logic signed [POS_W-1:0] off_x, off_y;
    logic signed [POS_W-1:0] nx_sum, ny_sum;
    logic signed [POS_W-1:0] side_s;
    logic                    inside_next;
    logic                    inside_reg;
    logic [COORD_W-1:0]      nx_reg, ny_reg;

    always_comb begin
        off_x       = POS_W'(prod_x_reg >>> FRAC_BITS);
        off_y       = POS_W'(prod_y_reg >>> FRAC_BITS);
        nx_sum      = $signed(POS_W'(rx_reg)) + off_x;
        ny_sum      = $signed(POS_W'(ry_reg)) + off_y;
        side_s      = $signed(POS_W'(side));
        inside_next = !nx_sum[POS_W-1] && !ny_sum[POS_W-1]
                      && (nx_sum < side_s) && (ny_sum < side_s);
    end

    always_ff @(posedge aclk) begin
        if (cmd.pos) begin
            inside_reg <= inside_next;
            nx_reg     <= COORD_W'(nx_sum);
            ny_reg     <= COORD_W'(ny_sum);
        end
    end

    // row-major cell index with the active side
    logic [IDX_W-1:0] idx_reg, idx_next;

    assign idx_next = IDX_W'(IDX_W'(nx_reg) * IDX_W'(side) + IDX_W'(ny_reg));

    always_ff @(posedge aclk) begin
        if (cmd.addr) begin
            idx_reg <= idx_next;
        end
    end

    // count ram read-modify-write
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] count_inc;

    assign count_inc = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
    assign ram_we    = cmd.clear_step || (cmd.finish && inside_reg);
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : idx_reg;
    assign ram_wdata = cmd.clear_step ? '0 : count_inc;

    cgu_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // output register
    logic      m_valid_reg;
    out_word_t m_data_reg, m_data_next;

    always_comb begin
        m_data_next = '0;
        if (inside_reg) begin
            m_data_next.in_grid   = 1'b1;
            m_data_next.hit_x     = COORD_OUT_W'(nx_reg);
            m_data_next.hit_y     = COORD_OUT_W'(ny_reg);
            m_data_next.hit_count = COUNT_OUT_W'(count_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign sts.out_busy = m_valid_reg && !m_ready;

    `CGU_ASSERT_NEXT(a_finish_shows_word, cmd.finish, m_valid_reg, "finished word not shown")
    `CGU_ASSERT_NOW(a_miss_is_zero, m_valid_reg && !m_data_reg.in_grid,
        m_data_reg.hit_x == '0 && m_data_reg.hit_y == '0 && m_data_reg.hit_count == '0,
        "outside word carries nonzero fields")
    `CGU_ASSERT_NOW(a_write_only_inside, ram_we && !cmd.clear_step, inside_reg,
        "count written for a cell outside the grid")

endmodule

/* design/certainty_grid_update_core.sv */
// top level of the certainty grid update core: sequencer plus datapath
// depends on cgu_pkg, cgu_ctrl, cgu_datapath
//
//   channel   ports                           direction
//   s_        s_valid, s_ready, s_data        range reading word in
//   m_        m_valid, m_ready, m_data        hit word out
//   cfg_      cfg_we, cfg_index, cfg_wdata    register write, no wait
//
// one word in work at a time: accept, then the radix-2 divider,
// then multiply, locate, index, ram read and update, in that order.
// after reset a clearing pass writes zero to all GRID_MAX*GRID_MAX counts;
// s_ready stays low until it ends.
// a finished word waits in the output register; a stalled m_ready holds the
// update step only, and the next word is taken once the update is written.
`include "certainty_grid_update_core_macros.svh"

module certainty_grid_update_core
    import cgu_pkg::*;
#(
    parameter int GRID_MAX   = CGU_GRID_MAX,
    parameter int COUNT_BITS = CGU_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    cgu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cgu_datapath #(
        .GRID_MAX   (GRID_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    `CGU_ASSERT_NEXT(a_one_word_at_a_time, s_valid && s_ready, !s_ready,
        "second word taken while one is in work")

endmodule
